// ===== hdl/blpe_pkg.sv =====
package blpe_pkg;

   // field widths
   localparam int NOW_W    = 32;
   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int HALF_W   = 15;
   localparam int INTV_W   = 16;
   localparam int TICK_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int BITS_PER_FRAME_DEF = 24;

   // serial divider
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 16;
   localparam int DIV_STEP_W = 6;

   localparam logic [DIV_STEP_W-1:0] MOD_STEPS   = 6'd32;  // now_ms mod period
   localparam logic [DIV_STEP_W-1:0] WAVE_STEPS  = 6'd23;  // fold * 255 / half
   localparam logic [DIV_STEP_W-1:0] SCALE_STEPS = 6'd16;  // span * wave / 255

   localparam logic [DIV_DEN_W-1:0] FULL_SCALE = 16'd255;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS = 3'd5;

   // register reset values
   localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 15'd1200;
   localparam logic [CHAN_W-1:0] MIN_LEVEL_RST   = 8'd8;
   localparam logic [CHAN_W-1:0] MAX_LEVEL_RST   = 8'd96;
   localparam logic [INTV_W-1:0] INTERVAL_RST    = 16'd60;
   localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 8'd8;
   localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 8'd4;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_ctrl_type;

endpackage

// ===== hdl/blpe_serdiv.sv =====
// Restoring divider, one quotient bit per cycle. The numerator comes in
// left-aligned; once 'steps' bits are shifted in, the quotient sits in the low bits.
module blpe_serdiv (
   input  logic                                clock,
   input  logic                                reset,
   input  blpe_pkg::div_ctrl_type              ctrl,
   input  logic [blpe_pkg::DIV_NUM_W-1:0]      num,
   input  logic [blpe_pkg::DIV_DEN_W-1:0]      den,
   output logic                                done,
   output logic [blpe_pkg::DIV_NUM_W-1:0]      quot,
   output logic [blpe_pkg::DIV_DEN_W-1:0]      rem
);

   logic [blpe_pkg::DIV_NUM_W-1:0]  shift_ff, shift_in;
   logic [blpe_pkg::DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [blpe_pkg::DIV_DEN_W-1:0]  den_ff, den_in;
   logic [blpe_pkg::DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [blpe_pkg::DIV_DEN_W:0]    trial;
   logic                            fits;

   assign trial = {rem_ff, shift_ff[blpe_pkg::DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         shift_in = num;
         rem_in   = '0;
         den_in   = den;
         cnt_in   = ctrl.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[blpe_pkg::DIV_NUM_W-2:0], fits};
         rem_in   = fits ? blpe_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                         : trial[blpe_pkg::DIV_DEN_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == blpe_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign done = done_ff;
   assign quot = shift_ff;
   assign rem  = rem_ff;

endmodule

// ===== hdl/breathing_led_pulse_encoder.sv =====
// Breathing LED pulse encoder.
// req_* carries one transaction: a breathing tick (req_kind 0, req_now_ms) or
// a direct color write (req_kind 1, req_red/green/blue). Each accepted
// transaction that is not dropped yields BITS_PER_FRAME rsp_* transactions,
// one per pulse symbol, GRB order MSB first, rsp_last on the final one.
// csr_* writes a register at any edge with csr_we high; write only while idle.
// A tick whose elapsed time is below the update interval gives no symbols.
// Direct write: first symbol in the cycle after accept. Tick: an interval
// check, then up to three passes through one bit-serial divider (phase,
// triangle wave, level scaling; scaling is skipped when the max level is
// below the min) before the first symbol. Symbols then go out one per
// cycle while rsp_stall is low. One transaction at a time: req_stall stays
// high until the last symbol of a frame is taken, also while rsp_stall holds
// the output, or until a dropped tick is checked. A stalled symbol holds.
// Reset (synchronous) returns registers to their defaults, clears the last
// update time to zero and empties the block.
module breathing_led_pulse_encoder #(
   parameter int BITS_PER_FRAME = blpe_pkg::BITS_PER_FRAME_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [blpe_pkg::NOW_W-1:0]            req_now_ms,
   input  logic [blpe_pkg::CHAN_W-1:0]           req_red,
   input  logic [blpe_pkg::CHAN_W-1:0]           req_green,
   input  logic [blpe_pkg::CHAN_W-1:0]           req_blue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_data_bit,
   output logic [blpe_pkg::TICK_W-1:0]           rsp_high_ticks,
   output logic [blpe_pkg::TICK_W-1:0]           rsp_low_ticks,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [blpe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [blpe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(BITS_PER_FRAME);
   localparam int PAD_W = BITS_PER_FRAME - blpe_pkg::COLOR_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_WAVE  = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   function automatic logic [BITS_PER_FRAME-1:0] frame_word(
      input logic [blpe_pkg::COLOR_W-1:0] grb
   );
      frame_word = BITS_PER_FRAME'(grb) << PAD_W;
   endfunction

   state_type state_ff, state_in;

   logic [blpe_pkg::NOW_W-1:0]  now_ff, now_in;
   logic [blpe_pkg::NOW_W-1:0]  last_ff, last_in;
   logic [BITS_PER_FRAME-1:0]   frame_ff, frame_in;
   logic [CNT_W-1:0]            sym_cnt_ff, sym_cnt_in;

   logic [blpe_pkg::HALF_W-1:0] half_ff, half_in;
   logic [blpe_pkg::CHAN_W-1:0] min_ff, min_in;
   logic [blpe_pkg::CHAN_W-1:0] max_ff, max_in;
   logic [blpe_pkg::INTV_W-1:0] intv_ff, intv_in;
   logic [blpe_pkg::TICK_W-1:0] long_ff, long_in;
   logic [blpe_pkg::TICK_W-1:0] short_ff, short_in;

   blpe_pkg::div_ctrl_type          div_ctrl;
   logic [blpe_pkg::DIV_NUM_W-1:0]  div_num;
   logic [blpe_pkg::DIV_DEN_W-1:0]  div_den;
   logic                            div_done;
   logic [blpe_pkg::DIV_NUM_W-1:0]  div_quot;
   logic [blpe_pkg::DIV_DEN_W-1:0]  div_rem;

   logic [blpe_pkg::HALF_W-1:0]     half_eff;
   logic [blpe_pkg::DIV_DEN_W-1:0]  period;
   logic [blpe_pkg::HALF_W-1:0]     fold;
   logic [blpe_pkg::HALF_W+7:0]     fold_x255;
   logic [blpe_pkg::NOW_W-1:0]      elapsed;
   logic [blpe_pkg::CHAN_W-1:0]     span;
   logic [2*blpe_pkg::CHAN_W-1:0]   prod;
   logic                            sym_last;

   blpe_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // zero half period behaves as 1 ms
   assign half_eff  = (half_ff == '0) ? blpe_pkg::HALF_W'(1) : half_ff;
   assign period    = {half_eff, 1'b0};
   assign fold      = (div_rem < {1'b0, half_eff}) ? div_rem[blpe_pkg::HALF_W-1:0]
                                                   : blpe_pkg::HALF_W'(period - div_rem);
   assign fold_x255 = {fold, 8'b0} - {8'b0, fold};
   assign elapsed   = now_ff - last_ff;
   assign span      = max_ff - min_ff;
   assign prod      = {8'b0, span} * {8'b0, div_quot[blpe_pkg::CHAN_W-1:0]};
   assign sym_last  = sym_cnt_ff == CNT_W'(BITS_PER_FRAME - 1);

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      last_in        = last_ff;
      frame_in       = frame_ff;
      sym_cnt_in     = sym_cnt_ff;
      div_ctrl.start = 1'b0;
      div_ctrl.steps = blpe_pkg::MOD_STEPS;
      div_num        = '0;
      div_den        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ms;
               if (req_kind) begin
                  frame_in   = frame_word({req_green, req_red, req_blue});
                  sym_cnt_in = '0;
                  state_in   = ST_SEND;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (elapsed < {16'b0, intv_ff}) begin
               state_in = ST_IDLE;
            end else begin
               last_in        = now_ff;
               div_ctrl.start = 1'b1;
               div_ctrl.steps = blpe_pkg::MOD_STEPS;
               div_num        = now_ff;
               div_den        = period;
               state_in       = ST_MOD;
            end
         end
         ST_MOD: begin
            // remainder is the phase within the period
            if (div_done) begin
               div_ctrl.start = 1'b1;
               div_ctrl.steps = blpe_pkg::WAVE_STEPS;
               div_num        = {fold_x255, 9'b0};
               div_den        = {1'b0, half_eff};
               state_in       = ST_WAVE;
            end
         end
         ST_WAVE: begin
            if (div_done) begin
               if (max_ff >= min_ff) begin
                  div_ctrl.start = 1'b1;
                  div_ctrl.steps = blpe_pkg::SCALE_STEPS;
                  div_num        = {prod, 16'b0};
                  div_den        = blpe_pkg::FULL_SCALE;
                  state_in       = ST_SCALE;
               end else begin
                  frame_in   = frame_word({16'b0, min_ff});
                  sym_cnt_in = '0;
                  state_in   = ST_SEND;
               end
            end
         end
         ST_SCALE: begin
            if (div_done) begin
               frame_in   = frame_word({16'b0, min_ff + div_quot[blpe_pkg::CHAN_W-1:0]});
               sym_cnt_in = '0;
               state_in   = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               frame_in   = frame_ff << 1;
               sym_cnt_in = sym_cnt_ff + 1'b1;
               if (sym_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      half_in  = half_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      intv_in  = intv_ff;
      long_in  = long_ff;
      short_in = short_ff;
      if (csr_we) begin
         case (csr_index)
            blpe_pkg::CSR_HALF_PERIOD: half_in  = csr_wdata[blpe_pkg::HALF_W-1:0];
            blpe_pkg::CSR_MIN_LEVEL:   min_in   = csr_wdata[blpe_pkg::CHAN_W-1:0];
            blpe_pkg::CSR_MAX_LEVEL:   max_in   = csr_wdata[blpe_pkg::CHAN_W-1:0];
            blpe_pkg::CSR_INTERVAL:    intv_in  = csr_wdata;
            blpe_pkg::CSR_LONG_TICKS:  long_in  = csr_wdata[blpe_pkg::TICK_W-1:0];
            blpe_pkg::CSR_SHORT_TICKS: short_in = csr_wdata[blpe_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         last_ff    <= '0;
         sym_cnt_ff <= '0;
         half_ff    <= blpe_pkg::HALF_PERIOD_RST;
         min_ff     <= blpe_pkg::MIN_LEVEL_RST;
         max_ff     <= blpe_pkg::MAX_LEVEL_RST;
         intv_ff    <= blpe_pkg::INTERVAL_RST;
         long_ff    <= blpe_pkg::LONG_TICKS_RST;
         short_ff   <= blpe_pkg::SHORT_TICKS_RST;
      end else begin
         state_ff   <= state_in;
         last_ff    <= last_in;
         sym_cnt_ff <= sym_cnt_in;
         half_ff    <= half_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         intv_ff    <= intv_in;
         long_ff    <= long_in;
         short_ff   <= short_in;
      end
      now_ff   <= now_in;
      frame_ff <= frame_in;
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = state_ff == ST_SEND;
   assign rsp_data_bit   = frame_ff[BITS_PER_FRAME-1];
   assign rsp_high_ticks = rsp_data_bit ? long_ff : short_ff;
   assign rsp_low_ticks  = rsp_data_bit ? short_ff : long_ff;
   assign rsp_last       = sym_last;

endmodule

// ===== hdl/blpe_checker.sv =====
module blpe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_data_bit,
   input logic [blpe_pkg::TICK_W-1:0]  rsp_high_ticks,
   input logic [blpe_pkg::TICK_W-1:0]  rsp_low_ticks,
   input logic                         rsp_last
);

   // one transaction in flight: input closes right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a transaction is in flight");

   a_no_accept_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while symbols are pending");

   // direct color write starts its frame on the next cycle
   a_direct_write_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind) |=> (rsp_valid && !rsp_last))
      else $error("direct write did not start a frame");

   a_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid)
      else $error("symbol after end of frame");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data_bit)
         && $stable(rsp_high_ticks) && $stable(rsp_low_ticks) && $stable(rsp_last)))
      else $error("stalled symbol changed");

endmodule

bind breathing_led_pulse_encoder blpe_checker u_blpe_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int NOW_W      = blpe_pkg::NOW_W;
   localparam int COLOR_W    = blpe_pkg::COLOR_W;
   localparam int CHAN_W     = blpe_pkg::CHAN_W;
   localparam int HALF_W     = blpe_pkg::HALF_W;
   localparam int INTV_W     = blpe_pkg::INTV_W;
   localparam int TICK_W     = blpe_pkg::TICK_W;
   localparam int CSR_IDX_W  = blpe_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = blpe_pkg::CSR_DATA_W;

   localparam int FRAME_BITS    = blpe_pkg::BITS_PER_FRAME_DEF;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 34;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_COLOR = 1'b1;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_1 = 3'd7;

   typedef struct {
      logic              kind;
      logic [NOW_W-1:0]  now_ms;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } led_req_type;

   typedef struct packed {
      logic              data_bit;
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] low_ticks;
      logic              last;
   } pulse_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_TICK;
   logic [NOW_W-1:0]      req_now_ms = '0;
   logic [CHAN_W-1:0]     req_red = '0;
   logic [CHAN_W-1:0]     req_green = '0;
   logic [CHAN_W-1:0]     req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_data_bit;
   logic [TICK_W-1:0]     rsp_high_ticks;
   logic [TICK_W-1:0]     rsp_low_ticks;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the last accepted tick time
   logic [HALF_W-1:0] cfg_half_ms     = blpe_pkg::HALF_PERIOD_RST;
   logic [CHAN_W-1:0] cfg_min_level   = blpe_pkg::MIN_LEVEL_RST;
   logic [CHAN_W-1:0] cfg_max_level   = blpe_pkg::MAX_LEVEL_RST;
   logic [INTV_W-1:0] cfg_interval_ms = blpe_pkg::INTERVAL_RST;
   logic [TICK_W-1:0] cfg_long_ticks  = blpe_pkg::LONG_TICKS_RST;
   logic [TICK_W-1:0] cfg_short_ticks = blpe_pkg::SHORT_TICKS_RST;
   logic [NOW_W-1:0]  last_tick_ms    = '0;

   led_req_type led_req_todo[$];
   led_req_type offered_req;
   pulse_type   pulses_due[$];
   pulse_type   pulse_want;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_left     = 0;
   logic        hold_req      = 1'b0;
   logic        hold_done     = 1'b0;

   breathing_led_pulse_encoder #(
      .BITS_PER_FRAME(FRAME_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_now_ms    (req_now_ms),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_bit  (rsp_data_bit),
      .rsp_high_ticks(rsp_high_ticks),
      .rsp_low_ticks (rsp_low_ticks),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // blue level of the breathing ramp at a given time
   function automatic logic [CHAN_W-1:0] breathing_blue(input logic [NOW_W-1:0] now_ms);
      int unsigned half;
      int unsigned period;
      int unsigned phase;
      int unsigned wave;
      int unsigned span;
      half = (cfg_half_ms == '0) ? 1 : cfg_half_ms;
      period = 2 * half;
      phase = now_ms % period;
      if (phase < half) wave = (phase * 255) / half;
      else wave = ((period - phase) * 255) / half;
      if (cfg_max_level < cfg_min_level) return cfg_min_level;
      span = cfg_max_level - cfg_min_level;
      return CHAN_W'(cfg_min_level + (span * wave) / 255);
   endfunction

   function automatic void queue_frame(input logic [CHAN_W-1:0] r, g, b);
      logic [FRAME_BITS-1:0] word;
      pulse_type sym;
      word = {g, r, b};
      word = word << (FRAME_BITS - COLOR_W);
      for (int k = 0; k < FRAME_BITS; k++) begin
         sym.data_bit   = word[FRAME_BITS-1-k];
         sym.high_ticks = sym.data_bit ? cfg_long_ticks : cfg_short_ticks;
         sym.low_ticks  = sym.data_bit ? cfg_short_ticks : cfg_long_ticks;
         sym.last       = (k == FRAME_BITS - 1);
         pulses_due.push_back(sym);
      end
   endfunction

   function automatic void predict_led_req(input led_req_type t);
      if (t.kind == KIND_COLOR) begin
         queue_frame(t.red, t.green, t.blue);
      end else if (NOW_W'(t.now_ms - last_tick_ms) >= cfg_interval_ms) begin
         last_tick_ms = t.now_ms;
         queue_frame('0, '0, breathing_blue(t.now_ms));
      end
   endfunction

   function automatic void add_tick(input logic [NOW_W-1:0] now_ms);
      led_req_type t;
      t.kind   = KIND_TICK;
      t.now_ms = now_ms;
      t.red    = CHAN_W'($urandom);
      t.green  = CHAN_W'($urandom);
      t.blue   = CHAN_W'($urandom);
      led_req_todo.push_back(t);
   endfunction

   function automatic void add_color(input logic [CHAN_W-1:0] r, g, b);
      led_req_type t;
      t.kind   = KIND_COLOR;
      t.now_ms = $urandom;
      t.red    = r;
      t.green  = g;
      t.blue   = b;
      led_req_todo.push_back(t);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         blpe_pkg::CSR_HALF_PERIOD: cfg_half_ms     = value[HALF_W-1:0];
         blpe_pkg::CSR_MIN_LEVEL:   cfg_min_level   = value[CHAN_W-1:0];
         blpe_pkg::CSR_MAX_LEVEL:   cfg_max_level   = value[CHAN_W-1:0];
         blpe_pkg::CSR_INTERVAL:    cfg_interval_ms = value[INTV_W-1:0];
         blpe_pkg::CSR_LONG_TICKS:  cfg_long_ticks  = value[TICK_W-1:0];
         blpe_pkg::CSR_SHORT_TICKS: cfg_short_ticks = value[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] half, lo, hi, gap, lng, sht);
      write_reg(blpe_pkg::CSR_HALF_PERIOD, half);
      write_reg(blpe_pkg::CSR_MIN_LEVEL, lo);
      write_reg(blpe_pkg::CSR_MAX_LEVEL, hi);
      write_reg(blpe_pkg::CSR_INTERVAL, gap);
      write_reg(blpe_pkg::CSR_LONG_TICKS, lng);
      write_reg(blpe_pkg::CSR_SHORT_TICKS, sht);
      @(negedge clock);
   endtask

   // dropped ticks give no symbols, so wait out the block's latency as well
   task automatic settle();
      do @(negedge clock);
      while (led_req_todo.size() != 0 || req_valid || pulses_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (req_valid && !req_stall) predict_led_req(offered_req);
      if (!reset && (!req_valid || !req_stall)) begin
         if (led_req_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            offered_req = led_req_todo.pop_front();
            req_valid  <= 1'b1;
            req_kind   <= offered_req.kind;
            req_now_ms <= offered_req.now_ms;
            req_red    <= offered_req.red;
            req_green  <= offered_req.green;
            req_blue   <= offered_req.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulses_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected symbol: bit %b high %0d low %0d last %b",
                        $realtime, rsp_data_bit, rsp_high_ticks, rsp_low_ticks, rsp_last);
         end else begin
            pulse_want = pulses_due.pop_front();
            if (rsp_data_bit !== pulse_want.data_bit ||
                rsp_high_ticks !== pulse_want.high_ticks ||
                rsp_low_ticks !== pulse_want.low_ticks ||
                rsp_last !== pulse_want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch: exp %b/%0d/%0d/%b got %b/%0d/%0d/%b",
                           $realtime, pulse_want.data_bit, pulse_want.high_ticks,
                           pulse_want.low_ticks, pulse_want.last, rsp_data_bit,
                           rsp_high_ticks, rsp_low_ticks, rsp_last);
            end
         end
      end
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
   end

   // one long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [NOW_W-1:0] ms;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: interval edges, wrap of the elapsed time, ramp ends
      add_tick(32'd0);
      add_tick(32'd59);
      add_tick(32'd60);
      add_color(8'h00, 8'h00, 8'h00);
      add_tick(32'd1200);
      add_tick(32'd2399);
      add_tick(32'd2400);
      add_tick(32'd3600);
      add_color(8'hFF, 8'hFF, 8'hFF);
      add_tick(32'hFFFF_FFFF);
      add_tick(32'd30);
      add_tick(32'd58);
      add_tick(32'd59);
      add_color(8'h80, 8'h01, 8'hA5);
      settle();

      // zero half period, zero interval, full range, zero tick counts
      write_all(16'd0, 16'd0, 16'd255, 16'd0, 16'd0, 16'd0);
      write_reg(CSR_SPARE_0, 16'hFFFF);
      write_reg(CSR_SPARE_1, 16'hFFFF);
      @(negedge clock);
      add_tick(32'd5);
      add_tick(32'd5);
      add_tick(32'd6);
      add_tick(32'h8000_0000);
      add_color(8'h55, 8'hAA, 8'h3C);
      settle();

      // widest half period (top data bit masked), max below min, longest interval
      write_all(16'hFFFF, 16'd200, 16'd10, 16'hFFFF, 16'd255, 16'd255);
      add_tick(32'h8000_FFFE);
      add_tick(32'h8000_FFFF);
      add_tick(32'h8001_FFFE);
      add_color(8'h12, 8'h34, 8'h56);

      ms = 32'h8002_0000;
      for (int p = 0; p < 4; p++) begin
         settle();
         write_all(($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom)
                                               : CSR_DATA_W'($urandom_range(1, 400)),
                   CSR_DATA_W'($urandom_range(0, 255)),
                   CSR_DATA_W'($urandom_range(0, 255)),
                   ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom)
                                               : CSR_DATA_W'($urandom_range(0, 120)),
                   CSR_DATA_W'($urandom_range(0, 255)),
                   CSR_DATA_W'($urandom_range(0, 255)));
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         if (p == 0) begin
            @(posedge clock);
            hold_req <= 1'b1;
            @(negedge clock);
         end
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 55) begin
               if ($urandom_range(0, 15) == 0) ms = $urandom;
               else ms = ms + $urandom_range(0, 150);
               add_tick(ms);
            end else begin
               add_color(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
            end
         end
      end
      settle();

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
